[sv/cpa_pkg.sv]
package cpa_pkg;

  localparam int CPA_UID_MAX_BYTES = 10;
  localparam int CPA_UID_FIELD_BYTES = 10;
  localparam int CPA_UID_BITS = 8 * CPA_UID_FIELD_BYTES;

  localparam int CPA_IN_TDATA_BITS = 120;
  localparam int CPA_OUT_TDATA_BITS = 8;
  localparam int CPA_APB_ADDR_BITS = 6;
  localparam int CPA_APB_DATA_BITS = 64;
  localparam int CPA_REG_INDEX_BITS = 3;

  localparam logic [CPA_REG_INDEX_BITS-1:0] REG_READER_OPERATIONAL = 3'd0;
  localparam logic [CPA_REG_INDEX_BITS-1:0] REG_AUTH_UID_LOW = 3'd1;
  localparam logic [CPA_REG_INDEX_BITS-1:0] REG_AUTH_UID_HIGH = 3'd2;
  localparam logic [CPA_REG_INDEX_BITS-1:0] REG_AUTH_UID_LENGTH = 3'd3;
  localparam logic [CPA_REG_INDEX_BITS-1:0] REG_GRACE_PERIOD = 3'd4;

  localparam logic [3:0] AUTH_UID_LENGTH_RESET = 4'd4;
  localparam logic [31:0] GRACE_PERIOD_RESET = 32'd1000;

  typedef struct packed {
    logic        reader_operational;
    logic [63:0] authorized_uid_low;
    logic [15:0] authorized_uid_high;
    logic [3:0]  auth_uid_len;
    logic [31:0] grace_period_ms;
  } cpa_cfg_t;

  typedef struct packed {
    logic [15:0] uid_high;
    logic [63:0] uid_low;
    logic [3:0]  uid_length;
    logic        detected;
    logic [31:0] now_ms;
  } cpa_item_t;

  typedef struct packed {
    logic credential_lost;
    logic auth_failed;
    logic auth_success;
    logic new_uid_seen;
    logic authorized_level;
  } cpa_result_t;

endpackage

[sv/cpa_regs.sv]
module cpa_regs
  import cpa_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CPA_APB_ADDR_BITS-1:0] paddr,
  input  logic [CPA_APB_DATA_BITS-1:0] pwdata,
  output logic [CPA_APB_DATA_BITS-1:0] prdata,
  output logic                         pready,
  output cpa_cfg_t                     cfg_o
);

  cpa_cfg_t                      cfg_q;
  logic                          wr_en;
  logic [CPA_REG_INDEX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CPA_APB_ADDR_BITS-1:CPA_APB_ADDR_BITS-CPA_REG_INDEX_BITS];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reader_operational  <= 1'b0;
      cfg_q.authorized_uid_low  <= '0;
      cfg_q.authorized_uid_high <= '0;
      cfg_q.auth_uid_len        <= AUTH_UID_LENGTH_RESET;
      cfg_q.grace_period_ms     <= GRACE_PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_READER_OPERATIONAL: cfg_q.reader_operational <= pwdata[0];
        REG_AUTH_UID_LOW:       cfg_q.authorized_uid_low <= pwdata;
        REG_AUTH_UID_HIGH:      cfg_q.authorized_uid_high <= pwdata[15:0];
        REG_AUTH_UID_LENGTH:    cfg_q.auth_uid_len <= pwdata[3:0];
        REG_GRACE_PERIOD:       cfg_q.grace_period_ms <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_READER_OPERATIONAL: prdata = {63'd0, cfg_q.reader_operational};
      REG_AUTH_UID_LOW:       prdata = cfg_q.authorized_uid_low;
      REG_AUTH_UID_HIGH:      prdata = {48'd0, cfg_q.authorized_uid_high};
      REG_AUTH_UID_LENGTH:    prdata = {60'd0, cfg_q.auth_uid_len};
      REG_GRACE_PERIOD:       prdata = {32'd0, cfg_q.grace_period_ms};
      default:                prdata = '0;
    endcase
  end

endmodule

[sv/cpa_core.sv]
module cpa_core
  import cpa_pkg::*;
#(
  parameter int UID_MAX_BYTES = CPA_UID_MAX_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cpa_cfg_t    cfg_i,
  input  cpa_item_t   item_i,
  input  logic        update_i,
  output cpa_result_t result_o
);

  localparam logic [3:0] MaxLen = 4'(UID_MAX_BYTES);

  logic                              is_auth_q, is_auth_d;
  logic                              observed_q, observed_d;
  logic                              atv_q, atv_d;
  logic [31:0]                       auth_time_q, auth_time_d;
  logic [31:0]                       seen_time_q, seen_time_d;
  logic [UID_MAX_BYTES-1:0][7:0]     rem_uid_q, rem_uid_d;
  logic [3:0]                        rem_len_q, rem_len_d;

  logic [CPA_UID_BITS-1:0] uid_all;
  logic [CPA_UID_BITS-1:0] auth_all;
  logic                    card_valid;
  logic                    match_rem;
  logic                    match_auth;
  logic                    fresh;
  logic [31:0]             seen_age;
  logic [31:0]             auth_age;

  assign uid_all    = {item_i.uid_high, item_i.uid_low};
  assign auth_all   = {cfg_i.authorized_uid_high, cfg_i.authorized_uid_low};
  assign card_valid = item_i.detected && (item_i.uid_length != 4'd0)
                      && (item_i.uid_length <= MaxLen);
  assign seen_age   = item_i.now_ms - seen_time_q;
  assign auth_age   = item_i.now_ms - auth_time_q;
  assign fresh      = !observed_q || !match_rem;

  always_comb begin
    match_rem  = (item_i.uid_length == rem_len_q);
    match_auth = (item_i.uid_length == cfg_i.auth_uid_len);
    for (int i = 0; i < UID_MAX_BYTES; i++) begin
      if (4'(i) < item_i.uid_length) begin
        if (uid_all[8*i +: 8] != rem_uid_q[i]) match_rem = 1'b0;
        if (uid_all[8*i +: 8] != auth_all[8*i +: 8]) match_auth = 1'b0;
      end
    end
  end

  always_comb begin
    is_auth_d   = is_auth_q;
    observed_d  = observed_q;
    atv_d       = atv_q;
    auth_time_d = auth_time_q;
    seen_time_d = seen_time_q;
    rem_uid_d   = rem_uid_q;
    rem_len_d   = rem_len_q;
    result_o    = '0;
    if (!cfg_i.reader_operational) begin
      is_auth_d = 1'b0;
    end else if (card_valid) begin
      observed_d  = 1'b1;
      seen_time_d = item_i.now_ms;
      if (fresh) begin
        rem_len_d             = item_i.uid_length;
        result_o.new_uid_seen = 1'b1;
        for (int i = 0; i < UID_MAX_BYTES; i++) begin
          if (4'(i) < item_i.uid_length) rem_uid_d[i] = uid_all[8*i +: 8];
        end
      end
      if (match_auth) begin
        auth_time_d = item_i.now_ms;
        atv_d       = 1'b1;
        if (!is_auth_q) begin
          is_auth_d             = 1'b1;
          result_o.auth_success = 1'b1;
        end
      end else begin
        is_auth_d            = 1'b0;
        atv_d                = 1'b0;
        result_o.auth_failed = fresh || is_auth_q;
      end
    end else begin
      if (observed_q && (seen_age >= cfg_i.grace_period_ms)) begin
        observed_d = 1'b0;
        rem_len_d  = 4'd0;
      end
      if (is_auth_q && atv_q && (auth_age >= cfg_i.grace_period_ms)) begin
        is_auth_d                = 1'b0;
        atv_d                    = 1'b0;
        result_o.credential_lost = 1'b1;
      end
    end
    result_o.authorized_level = cfg_i.reader_operational && is_auth_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_auth_q   <= 1'b0;
      observed_q  <= 1'b0;
      atv_q       <= 1'b0;
      auth_time_q <= '0;
      seen_time_q <= '0;
      rem_uid_q   <= '0;
      rem_len_q   <= '0;
    end else if (update_i) begin
      is_auth_q   <= is_auth_d;
      observed_q  <= observed_d;
      atv_q       <= atv_d;
      auth_time_q <= auth_time_d;
      seen_time_q <= seen_time_d;
      rem_uid_q   <= rem_uid_d;
      rem_len_q   <= rem_len_d;
    end
  end

endmodule

[sv/credential_presence_authorizer.sv]
// Pipeline: input register, then single-pass compare and flag update into the
// result register, each stage advancing when downstream frees. Throughput: one
// poll per cycle while m_axis_tready_i keeps the result register draining.
// Reset: rst_ni async active low; clears pipeline valids, presence/auth state,
// remembered UID, and loads register defaults (length 4, grace 1000 ms).
module credential_presence_authorizer
  import cpa_pkg::*;
#(
  parameter int UID_MAX_BYTES = CPA_UID_MAX_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_ms[31:0], detected[32], uid_length[36:33], uid_low[100:37],
  // uid_high[116:101], unused [119:117]
  input  logic [CPA_IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // authorized_level[0], new_uid_seen[1], auth_success[2], auth_failed[3],
  // credential_lost[4], zero fill [7:5]
  output logic [CPA_OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CPA_APB_ADDR_BITS-1:0]  paddr,
  input  logic [CPA_APB_DATA_BITS-1:0]  pwdata,
  output logic [CPA_APB_DATA_BITS-1:0]  prdata,
  output logic                          pready
);

  cpa_cfg_t    cfg;
  cpa_item_t   in_item_q;
  logic        in_valid_q, in_valid_d;
  cpa_result_t result;
  cpa_result_t out_res_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        fire;
  logic        s_accept;

  cpa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpa_core #(
    .UID_MAX_BYTES (UID_MAX_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (in_item_q),
    .update_i (fire),
    .result_o (result)
  );

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= cpa_item_t'(s_axis_tdata_i[$bits(cpa_item_t)-1:0]);
    end
    if (fire) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(CPA_OUT_TDATA_BITS - $bits(cpa_result_t)){1'b0}}, out_res_q};

endmodule

[sv/cpa_checker.sv]
module cpa_checker
  import cpa_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [CPA_OUT_TDATA_BITS-1:0] m_axis_tdata_o
);

  logic level, new_uid, success, failed, lost;

  assign level   = m_axis_tdata_o[0];
  assign new_uid = m_axis_tdata_o[1];
  assign success = m_axis_tdata_o[2];
  assign failed  = m_axis_tdata_o[3];
  assign lost    = m_axis_tdata_o[4];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_success_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && success |-> level && !failed && !lost)
    else $error("auth success without authorized level");

  a_failed_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && failed |-> !level && !lost)
    else $error("auth failed with authorized level");

  a_lost_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && lost |-> !level && !new_uid)
    else $error("credential lost on a card poll");

endmodule

bind credential_presence_authorizer cpa_checker u_cpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cpa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class auth_scoreboard;
    cpa_cfg_t    cfg;
    bit          authorized;
    bit          observed;
    bit          auth_time_valid;
    logic [31:0] last_auth_ms;
    logic [31:0] last_seen_ms;
    logic [79:0] remembered_uid;
    logic [3:0]  remembered_len;
    cpa_result_t pending_decisions[$];
    int          errors;
    int          results_seen;

    function new();
      cfg = '0;
      cfg.auth_uid_len = AUTH_UID_LENGTH_RESET;
      cfg.grace_period_ms = GRACE_PERIOD_RESET;
      authorized = 0;
      observed = 0;
      auth_time_valid = 0;
      last_auth_ms = '0;
      last_seen_ms = '0;
      remembered_uid = '0;
      remembered_len = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 25) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return pending_decisions.size();
    endfunction

    function void write_reg(logic [CPA_REG_INDEX_BITS-1:0] idx, logic [63:0] v);
      case (idx)
        REG_READER_OPERATIONAL: cfg.reader_operational = v[0];
        REG_AUTH_UID_LOW:       cfg.authorized_uid_low = v;
        REG_AUTH_UID_HIGH:      cfg.authorized_uid_high = v[15:0];
        REG_AUTH_UID_LENGTH:    cfg.auth_uid_len = v[3:0];
        REG_GRACE_PERIOD:       cfg.grace_period_ms = v[31:0];
        default: ;
      endcase
    endfunction

    function bit same_prefix(logic [79:0] a, logic [79:0] b, logic [3:0] n);
      for (int i = 0; i < CPA_UID_MAX_BYTES; i++)
        if (i < n && a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_poll(cpa_item_t p);
      cpa_result_t r;
      logic [79:0] uid;
      bit          card;
      bit          fresh;
      bit          was;
      r = '0;
      if (!cfg.reader_operational) begin
        authorized = 0;
        pending_decisions.push_back(r);
        return;
      end
      uid = {p.uid_high, p.uid_low};
      card = p.detected && p.uid_length != 0 && p.uid_length <= CPA_UID_MAX_BYTES;
      if (card) begin
        fresh = !observed || p.uid_length != remembered_len ||
                !same_prefix(uid, remembered_uid, p.uid_length);
        observed = 1;
        last_seen_ms = p.now_ms;
        if (fresh) begin
          remembered_len = p.uid_length;
          remembered_uid = uid;
          r.new_uid_seen = 1;
        end
        if (p.uid_length == cfg.auth_uid_len &&
            same_prefix(uid, {cfg.authorized_uid_high, cfg.authorized_uid_low},
                        p.uid_length)) begin
          last_auth_ms = p.now_ms;
          auth_time_valid = 1;
          if (!authorized) begin
            authorized = 1;
            r.auth_success = 1;
          end
        end else begin
          was = authorized;
          authorized = 0;
          auth_time_valid = 0;
          if (fresh || was) r.auth_failed = 1;
        end
      end else begin
        if (observed && 32'(p.now_ms - last_seen_ms) >= cfg.grace_period_ms) begin
          observed = 0;
          remembered_len = '0;
        end
        if (authorized && auth_time_valid &&
            32'(p.now_ms - last_auth_ms) >= cfg.grace_period_ms) begin
          authorized = 0;
          auth_time_valid = 0;
          r.credential_lost = 1;
        end
      end
      r.authorized_level = authorized;
      pending_decisions.push_back(r);
    endfunction

    function void check_result(cpa_result_t got);
      cpa_result_t want;
      string field_names[5] = '{"authorized_level", "new_uid_seen", "auth_success",
                                "auth_failed", "credential_lost"};
      if (pending_decisions.size() == 0) begin
        report("result transaction with no poll pending");
        return;
      end
      want = pending_decisions.pop_front();
      for (int i = 0; i < 5; i++)
        if (got[i] !== want[i])
          report($sformatf("result %0d %s: got %b expected %b", results_seen,
                           field_names[i], got[i], want[i]));
      results_seen++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [CPA_IN_TDATA_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [CPA_OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CPA_APB_ADDR_BITS-1:0] paddr = '0;
  logic [CPA_APB_DATA_BITS-1:0] pwdata = '0;
  logic [CPA_APB_DATA_BITS-1:0] prdata;
  logic pready;

  auth_scoreboard sb = new();
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 53;
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms = '0;
  logic [79:0] card_pool[4];
  logic [3:0]  card_len[4];

  credential_presence_authorizer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(cpa_result_t'(m_axis_tdata_o[$bits(cpa_result_t)-1:0]));
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_poll(cpa_item_t'(s_axis_tdata_i[$bits(cpa_item_t)-1:0]));
    end
  end

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CPA_REG_INDEX_BITS-1:0] idx, logic [63:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_poll(cpa_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= CPA_IN_TDATA_BITS'(p);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic poll(logic [31:0] now, logic det, logic [3:0] len, logic [63:0] lo,
                      logic [15:0] hi);
    cpa_item_t p;
    p.now_ms = now;
    p.detected = det;
    p.uid_length = len;
    p.uid_low = lo;
    p.uid_high = hi;
    send_poll(p);
  endtask

  task automatic shuffle_config();
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    logic [31:0] grace;
    int unsigned r;
    int unsigned b;
    lo = {$urandom, $urandom};
    hi = 16'($urandom);
    r = $urandom_range(99);
    if (r < 85) len = 4'($urandom_range(1, 10));
    else if (r < 90) len = 4'd0;
    else len = 4'($urandom_range(11, 15));
    r = $urandom_range(99);
    if (r < 50) grace = $urandom_range(1, 150);
    else if (r < 65) grace = '0;
    else if (r < 90) grace = $urandom_range(151, 3000);
    else grace = $urandom;
    cfg_write(REG_READER_OPERATIONAL, 64'($urandom_range(9) != 0));
    cfg_write(REG_AUTH_UID_LOW, lo);
    cfg_write(REG_AUTH_UID_HIGH, 64'(hi));
    cfg_write(REG_AUTH_UID_LENGTH, 64'(len));
    cfg_write(REG_GRACE_PERIOD, 64'(grace));
    card_pool[0] = {hi, lo};
    card_len[0] = (len != 0 && len <= CPA_UID_MAX_BYTES) ? len : 4'($urandom_range(1, 10));
    b = $urandom_range(card_len[0] - 1);
    card_pool[1] = card_pool[0];
    card_pool[1][8*b +: 8] = card_pool[1][8*b +: 8] ^ 8'($urandom_range(1, 255));
    card_len[1] = card_len[0];
    card_pool[2] = 80'({$urandom, $urandom, $urandom});
    card_len[2] = 4'($urandom_range(1, 10));
    card_pool[3] = card_pool[0];
    card_len[3] = 4'($urandom_range(1, 10));
  endtask

  task automatic send_random_poll();
    cpa_item_t   p;
    logic [79:0] uid;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) clock_ms = clock_ms + $urandom;
    else if ($urandom_range(9) == 0) clock_ms = clock_ms + $urandom_range(0, 400);
    else clock_ms = clock_ms + $urandom_range(0, 120);
    uid = 80'({$urandom, $urandom, $urandom});
    p.now_ms = clock_ms;
    p.detected = 1'b1;
    if (pick < 80) begin
      if (pick < 45) k = 0;
      else if (pick < 60) k = 1;
      else k = 2 + $urandom_range(1);
      for (int i = 0; i < CPA_UID_MAX_BYTES; i++)
        if (i < card_len[k]) uid[8*i +: 8] = card_pool[k][8*i +: 8];
      p.uid_length = card_len[k];
    end else if (pick < 88) begin
      p.uid_length = 4'($urandom_range(1, 10));
    end else begin
      p.detected = 1'($urandom_range(1));
      if (!p.detected) p.uid_length = 4'($urandom_range(15));
      else if ($urandom_range(2) == 0) p.uid_length = 4'd0;
      else p.uid_length = 4'($urandom_range(11, 15));
    end
    p.uid_low = uid[63:0];
    p.uid_high = uid[79:64];
    send_poll(p);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    poll(32'h0000_0000, 1'b1, 4'd4, 64'h0, 16'h0);
    cfg_write(REG_READER_OPERATIONAL, 64'd1);
    cfg_write(REG_AUTH_UID_LOW, '1);
    cfg_write(REG_AUTH_UID_HIGH, 64'hFFFF);
    cfg_write(REG_AUTH_UID_LENGTH, 64'd10);
    cfg_write(REG_GRACE_PERIOD, 64'd1000);
    poll(32'hFFFF_FF00, 1'b1, 4'd10, '1, '1);
    poll(32'hFFFF_FF10, 1'b1, 4'd10, '1, '1);
    poll(32'h0000_0100, 1'b0, 4'd0, '0, '0);
    poll(32'h0000_0150, 1'b1, 4'd0, '1, '1);
    poll(32'h0000_0200, 1'b1, 4'd15, '1, '1);
    poll(32'h0000_02F8, 1'b1, 4'd11, '1, '1);
    poll(32'h0000_0300, 1'b1, 4'd10, '1, 16'h7FFF);
    poll(32'h0000_0301, 1'b1, 4'd10, '1, 16'h7FFF);
    poll(32'h0000_0302, 1'b1, 4'd10, '1, '1);
    poll(32'h0000_0303, 1'b1, 4'd10, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    poll(32'h0000_0800, 1'b0, 4'd10, '1, '1);

    cfg_write(REG_AUTH_UID_LOW, 64'h0123_4567_89AB_CDEF);
    cfg_write(REG_AUTH_UID_LENGTH, 64'd4);
    cfg_write(REG_GRACE_PERIOD, 64'd0);
    poll(32'h0000_1000, 1'b1, 4'd4, 64'hFFFF_FFFF_89AB_CDEF, 16'h0000);
    poll(32'h0000_1001, 1'b1, 4'd4, 64'h0000_0000_89AB_CDEF, 16'h1234);
    poll(32'h0000_1002, 1'b1, 4'd5, 64'h0000_0000_89AB_CDEF, 16'h0000);
    poll(32'h0000_1003, 1'b1, 4'd4, 64'h0123_4567_89AB_CDEF, '1);
    poll(32'h0000_1003, 1'b0, 4'd4, '0, '0);

    cfg_write(REG_AUTH_UID_LENGTH, 64'd0);
    poll(32'h0000_2000, 1'b1, 4'd1, 64'hEF, 16'h0);
    cfg_write(REG_AUTH_UID_LENGTH, 64'd15);
    cfg_write(REG_GRACE_PERIOD, 64'hFFFF_FFFF);
    poll(32'h0000_2001, 1'b1, 4'd4, 64'h89AB_CDEF, 16'h0);
    poll(32'h0000_2000, 1'b0, 4'd0, '0, '0);
    cfg_write(REG_AUTH_UID_LENGTH, 64'd4);
    poll(32'h0000_3000, 1'b1, 4'd4, 64'h89AB_CDEF, 16'h0);
    cfg_write(REG_READER_OPERATIONAL, 64'd0);
    poll(32'h0000_3001, 1'b1, 4'd4, 64'h89AB_CDEF, 16'h0);
    cfg_write(REG_READER_OPERATIONAL, 64'd1);
    poll(32'h0000_3002, 1'b0, 4'd0, '0, '0);

    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 1) begin
        send_idle_pct = 53;
        recv_idle_pct = 27;
      end else if (mode == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int setting = 0; setting < 3; setting++) begin
        shuffle_config();
        repeat (50) begin
          if ($urandom_range(39) == 0) wait_idle();
          send_random_poll();
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cpa_pkg.sv
sv/cpa_regs.sv
sv/cpa_core.sv
sv/credential_presence_authorizer.sv
sv/cpa_checker.sv
dv/testbench.sv
